// File: sv/fbtc_pkg.sv
// ----------------------------------------------------------------------------
// Filter bank template classifier package
// Shared types, widths and codes of the classifier block.
// ----------------------------------------------------------------------------
`default_nettype none

package fbtc_pkg;

  localparam int CHANNELS   = 3;
  localparam int SLOTS      = 8;
  localparam int FRAC_BITS  = 12;

  localparam int RAW_W      = 8;
  localparam int MEAN_W     = FRAC_BITS + 1;
  localparam int CNT_W      = 16;
  localparam int TOL_W      = 13;
  localparam int SLOT_W     = 3;
  localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DVD_W      = MEAN_W + CNT_W + 1;
  localparam int DVD_CNT_W  = $clog2(DVD_W);

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(410);

  typedef enum logic [1:0] {
    FUNC_SAMPLE   = 2'd0,
    FUNC_COMMIT   = 2'd1,
    FUNC_CLASSIFY = 2'd2,
    FUNC_CLEAR    = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_NORM_WAIT,
    ST_FOLD,
    ST_FOLD_DIV,
    ST_FOLD_WAIT,
    ST_CMP,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [RAW_W-1:0]  filter_a;
    logic [RAW_W-1:0]  filter_b;
    logic [RAW_W-1:0]  filter_c;
    logic [SLOT_W-1:0] slot;
  } in_req_t;

  typedef struct packed {
    logic              matched;
    logic [SLOT_W-1:0] matched_slot;
    logic              ambiguous;
  } out_res_t;

endpackage

`default_nettype wire

// File: sv/fbtc_div.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// Produces one quotient bit per cycle; the low bits of the quotient are returned.
// ----------------------------------------------------------------------------
`default_nettype none

module fbtc_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [fbtc_pkg::DVD_W-1:0] dividend,
  input  wire logic [fbtc_pkg::CNT_W-1:0] divisor,
  output logic                            done,
  output logic [fbtc_pkg::MEAN_W-1:0]     quotient
);
  import fbtc_pkg::*;

  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [DVD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]     dsr_r, dsr_nxt;
  logic [CNT_W:0]       trial;
  logic                 fits;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, dvd_r[DVD_W-1]};
    fits     = trial >= {1'b0, dsr_r};
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      dvd_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
    end else if (run_r) begin
      rem_nxt = fits ? CNT_W'(trial - {1'b0, dsr_r}) : trial[CNT_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r + DVD_CNT_W'(1);
      if (cnt_r == DVD_CNT_W'(DVD_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r[MEAN_W-1:0];

endmodule

`default_nettype wire

// File: sv/filter_bank_template_classifier_unit.sv
// ----------------------------------------------------------------------------
// Filter bank template classifier
// Normalizes band magnitudes, keeps running means and matches templates.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A sample request
// normalizes the three magnitudes by their largest one and folds them into
// the working mean; a commit folds the working mean into a reference slot and
// clears it; a clear zeroes one slot. These give no result. A classify request
// compares the working mean with every slot and gives one result on the out_
// ports, marked by out_valid for a single cycle; the receiver cannot stall it.
// All divisions go through one shared divider. A sample normalizes each
// magnitude by a division, or sets all to zero when all magnitudes are zero,
// and then folds each channel in directly when it is the only held sample or
// by a division otherwise. A commit folds directly into an empty slot and by
// a division otherwise, and a clear finishes in the idle state. busy stays
// high from a taken sample, commit or classify until it is finished.
// The tolerance is written through cfg_we and cfg_wdata; the user must write
// it only while the block is idle, which the block itself does not enforce.
// Reset clears all means, counts and the reference store at once and sets the tolerance to 410.
// ----------------------------------------------------------------------------
`default_nettype none

module filter_bank_template_classifier_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire fbtc_pkg::in_req_t         in_req,
  output logic                           out_valid,
  output fbtc_pkg::out_res_t             out_res,
  input  wire logic                      cfg_we,
  input  wire logic [fbtc_pkg::TOL_W-1:0] cfg_wdata
);
  import fbtc_pkg::*;

  state_t               state_r, state_nxt;
  in_req_t              req_r, req_nxt;
  logic [RAW_W-1:0]     max_r, max_nxt;
  logic [CH_W-1:0]      ch_r, ch_nxt;
  logic [SLOT_IDX_W-1:0] p_r, p_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic                 tgt_ref_r, tgt_ref_nxt;
  logic [DVD_W-1:0]     prod_r, prod_nxt;
  logic                 ok_r, ok_nxt;
  logic                 found_r, found_nxt;
  logic                 multi_r, multi_nxt;
  logic [SLOT_IDX_W-1:0] first_r, first_nxt;
  logic [TOL_W-1:0]     tol_r, tol_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_res_t             out_r, out_nxt;

  logic [MEAN_W-1:0]    wmean_r [CHANNELS];
  logic [MEAN_W-1:0]    wmean_nxt [CHANNELS];
  logic [CNT_W-1:0]     wcnt_r, wcnt_nxt;
  logic [MEAN_W-1:0]    norm_r [CHANNELS];
  logic [MEAN_W-1:0]    norm_nxt [CHANNELS];
  logic [MEAN_W-1:0]    ref_r [SLOTS][CHANNELS];
  logic [MEAN_W-1:0]    ref_nxt [SLOTS][CHANNELS];
  logic [CNT_W-1:0]     rcnt_r [SLOTS];
  logic [CNT_W-1:0]     rcnt_nxt [SLOTS];

  logic                 div_start;
  logic [DVD_W-1:0]     div_dvd;
  logic [CNT_W-1:0]     div_dsr;
  logic                 div_done;
  logic [MEAN_W-1:0]    div_quo;

  logic [RAW_W-1:0]     raw_cur;
  logic [RAW_W-1:0]     in_max;
  logic [MEAN_W-1:0]    cur_mean;
  logic [MEAN_W-1:0]    cur_x;
  logic [SLOT_IDX_W-1:0] sidx;
  logic [MEAN_W-1:0]    cmp_a;
  logic [MEAN_W-1:0]    cmp_b;
  logic [MEAN_W-1:0]    diff;
  logic                 last_ch;
  logic                 slot_ok;

  fbtc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    max_nxt       = max_r;
    ch_nxt        = ch_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    tgt_ref_nxt   = tgt_ref_r;
    prod_nxt      = prod_r;
    ok_nxt        = ok_r;
    found_nxt     = found_r;
    multi_nxt     = multi_r;
    first_nxt     = first_r;
    tol_nxt       = cfg_we ? cfg_wdata : tol_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wmean_nxt     = wmean_r;
    wcnt_nxt      = wcnt_r;
    norm_nxt      = norm_r;
    ref_nxt       = ref_r;
    rcnt_nxt      = rcnt_r;
    div_start     = 1'b0;
    div_dvd       = prod_r;
    div_dsr       = n_r;

    in_max = (in_req.filter_a > in_req.filter_b) ? in_req.filter_a : in_req.filter_b;
    if (in_req.filter_c > in_max) begin
      in_max = in_req.filter_c;
    end

    case (ch_r)
      CH_W'(0): raw_cur = req_r.filter_a;
      CH_W'(1): raw_cur = req_r.filter_b;
      CH_W'(2): raw_cur = req_r.filter_c;
      default:  raw_cur = '0;
    endcase

    sidx     = req_r.slot[SLOT_IDX_W-1:0];
    last_ch  = ch_r == CH_W'(CHANNELS - 1);
    slot_ok  = int'(in_req.slot) < SLOTS;
    cur_mean = tgt_ref_r ? ref_r[sidx][ch_r] : wmean_r[ch_r];
    cur_x    = tgt_ref_r ? wmean_r[ch_r] : norm_r[ch_r];
    cmp_a    = ref_r[p_r][ch_r];
    cmp_b    = wmean_r[ch_r];
    diff     = (cmp_a > cmp_b) ? cmp_a - cmp_b : cmp_b - cmp_a;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt = in_req;
          max_nxt = in_max;
          ch_nxt  = '0;
          p_nxt   = '0;
          unique case (func_t'(in_req.func))
            FUNC_SAMPLE: begin
              wcnt_nxt    = (wcnt_r == '1) ? wcnt_r : wcnt_r + CNT_W'(1);
              n_nxt       = wcnt_nxt;
              tgt_ref_nxt = 1'b0;
              state_nxt   = ST_NORM;
            end
            FUNC_COMMIT: begin
              if (slot_ok) begin
                rcnt_nxt[in_req.slot[SLOT_IDX_W-1:0]] =
                  (rcnt_r[in_req.slot[SLOT_IDX_W-1:0]] == '1) ?
                  rcnt_r[in_req.slot[SLOT_IDX_W-1:0]] :
                  rcnt_r[in_req.slot[SLOT_IDX_W-1:0]] + CNT_W'(1);
                n_nxt       = rcnt_nxt[in_req.slot[SLOT_IDX_W-1:0]];
                tgt_ref_nxt = 1'b1;
                state_nxt   = ST_FOLD;
              end
            end
            FUNC_CLASSIFY: begin
              ok_nxt    = 1'b1;
              found_nxt = 1'b0;
              multi_nxt = 1'b0;
              first_nxt = '0;
              state_nxt = ST_CMP;
            end
            FUNC_CLEAR: begin
              if (slot_ok) begin
                for (int c = 0; c < CHANNELS; c++) begin
                  ref_nxt[in_req.slot[SLOT_IDX_W-1:0]][c] = '0;
                end
                rcnt_nxt[in_req.slot[SLOT_IDX_W-1:0]] = '0;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_NORM: begin
        if (max_r == '0) begin
          norm_nxt[ch_r] = '0;
          ch_nxt         = last_ch ? '0 : ch_r + CH_W'(1);
          state_nxt      = last_ch ? ST_FOLD : ST_NORM;
        end else begin
          div_start = 1'b1;
          div_dvd   = DVD_W'({raw_cur, FRAC_BITS'(0)}) + DVD_W'(max_r >> 1);
          div_dsr   = CNT_W'(max_r);
          state_nxt = ST_NORM_WAIT;
        end
      end
      ST_NORM_WAIT: begin
        if (div_done) begin
          norm_nxt[ch_r] = div_quo;
          ch_nxt         = last_ch ? '0 : ch_r + CH_W'(1);
          state_nxt      = last_ch ? ST_FOLD : ST_NORM;
        end
      end
      ST_FOLD: begin
        if (n_r == CNT_W'(1)) begin
          if (tgt_ref_r) begin
            ref_nxt[sidx][ch_r] = cur_x;
          end else begin
            wmean_nxt[ch_r] = cur_x;
          end
          ch_nxt = last_ch ? '0 : ch_r + CH_W'(1);
          if (last_ch) begin
            state_nxt = ST_IDLE;
            if (tgt_ref_r) begin
              for (int c = 0; c < CHANNELS; c++) begin
                wmean_nxt[c] = '0;
              end
              wcnt_nxt = '0;
            end
          end
        end else begin
          prod_nxt  = DVD_W'(cur_mean) * DVD_W'(n_r - CNT_W'(1)) + DVD_W'(cur_x)
                      + DVD_W'(n_r >> 1);
          state_nxt = ST_FOLD_DIV;
        end
      end
      ST_FOLD_DIV: begin
        div_start = 1'b1;
        state_nxt = ST_FOLD_WAIT;
      end
      ST_FOLD_WAIT: begin
        if (div_done) begin
          if (tgt_ref_r) begin
            ref_nxt[sidx][ch_r] = div_quo;
          end else begin
            wmean_nxt[ch_r] = div_quo;
          end
          ch_nxt    = last_ch ? '0 : ch_r + CH_W'(1);
          state_nxt = ST_FOLD;
          if (last_ch) begin
            state_nxt = ST_IDLE;
            if (tgt_ref_r) begin
              for (int c = 0; c < CHANNELS; c++) begin
                wmean_nxt[c] = '0;
              end
              wcnt_nxt = '0;
            end
          end
        end
      end
      ST_CMP: begin
        ok_nxt = ok_r && (diff <= tol_r);
        ch_nxt = last_ch ? '0 : ch_r + CH_W'(1);
        if (last_ch) begin
          if (ok_nxt) begin
            if (found_r) begin
              multi_nxt = 1'b1;
            end else begin
              found_nxt = 1'b1;
              first_nxt = p_r;
            end
          end
          ok_nxt = 1'b1;
          p_nxt  = p_r + SLOT_IDX_W'(1);
          if (p_r == SLOT_IDX_W'(SLOTS - 1)) begin
            state_nxt = ST_REPORT;
          end
        end
      end
      ST_REPORT: begin
        out_valid_nxt        = 1'b1;
        out_nxt.matched      = found_r && !multi_r;
        out_nxt.matched_slot = (found_r && !multi_r) ? SLOT_W'(first_r) : '0;
        out_nxt.ambiguous    = multi_r;
        state_nxt            = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tol_r       <= TOL_RESET;
      out_valid_r <= 1'b0;
      wcnt_r      <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        wmean_r[c] <= '0;
      end
      for (int s = 0; s < SLOTS; s++) begin
        rcnt_r[s] <= '0;
        for (int c = 0; c < CHANNELS; c++) begin
          ref_r[s][c] <= '0;
        end
      end
    end else begin
      state_r     <= state_nxt;
      tol_r       <= tol_nxt;
      out_valid_r <= out_valid_nxt;
      wcnt_r      <= wcnt_nxt;
      wmean_r     <= wmean_nxt;
      rcnt_r      <= rcnt_nxt;
      ref_r       <= ref_nxt;
    end
    req_r     <= req_nxt;
    max_r     <= max_nxt;
    ch_r      <= ch_nxt;
    p_r       <= p_nxt;
    n_r       <= n_nxt;
    tgt_ref_r <= tgt_ref_nxt;
    prod_r    <= prod_nxt;
    ok_r      <= ok_nxt;
    found_r   <= found_nxt;
    multi_r   <= multi_nxt;
    first_r   <= first_nxt;
    norm_r    <= norm_nxt;
    out_r     <= out_nxt;
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req.func == FUNC_CLASSIFY |=> busy)
    else $error("classify request did not start the slot walk");

  a_match_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_res.matched && out_res.ambiguous))
    else $error("result both matched and ambiguous");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.matched |-> out_res.matched_slot == '0)
    else $error("slot index given without a match");
`endif

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Filter bank template classifier testbench
// Drives sample, commit, classify and clear requests through the command
// port, predicts every classify result with its own model of the running
// means and reference store, and checks each result as it appears.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import fbtc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_req_t in_req = '0;
  logic out_valid;
  out_res_t out_res;
  logic cfg_we = 1'b0;
  logic [TOL_W-1:0] cfg_wdata = '0;

  filter_bank_template_classifier_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [TOL_W-1:0] tol_model;
  logic [MEAN_W-1:0] work_mean [CHANNELS];
  logic [CNT_W-1:0] work_cnt;
  logic [MEAN_W-1:0] ref_mean [SLOTS][CHANNELS];
  logic [CNT_W-1:0] ref_cnt [SLOTS];

  in_req_t pending_reqs [$];
  out_res_t expected_results [$];
  int errors = 0;
  int accepted = 0;
  int classified = 0;
  int idle_pct = 0;

  task automatic fold_into(inout logic [MEAN_W-1:0] mean [CHANNELS],
                           inout logic [CNT_W-1:0] cnt,
                           input logic [MEAN_W-1:0] vals [CHANNELS]);
    longint unsigned n, acc;
    if (cnt != 16'hFFFF) cnt = cnt + 1'b1;
    n = 64'(cnt);
    for (int i = 0; i < CHANNELS; i++) begin
      if (n == 1) begin
        mean[i] = vals[i];
      end else begin
        acc = 64'(mean[i]) * (n - 64'd1) + 64'(vals[i]) + n / 64'd2;
        mean[i] = MEAN_W'(acc / n);
      end
    end
  endtask

  task automatic predict_request(input in_req_t r);
    logic [MEAN_W-1:0] norm [CHANNELS];
    logic [MEAN_W-1:0] tmp [CHANNELS];
    logic [CNT_W-1:0] c;
    int unsigned raw [CHANNELS];
    int unsigned m, d, first;
    bit found, multi, ok;
    out_res_t res;
    case (func_t'(r.func))
      FUNC_SAMPLE: begin
        raw[0] = 32'(r.filter_a);
        raw[1] = 32'(r.filter_b);
        raw[2] = 32'(r.filter_c);
        m = 0;
        for (int i = 0; i < CHANNELS; i++) if (raw[i] > m) m = raw[i];
        for (int i = 0; i < CHANNELS; i++)
          norm[i] = (m == 0) ? '0 : MEAN_W'(((raw[i] << FRAC_BITS) + m / 2) / m);
        fold_into(work_mean, work_cnt, norm);
      end
      FUNC_COMMIT: begin
        tmp = ref_mean[r.slot];
        c = ref_cnt[r.slot];
        fold_into(tmp, c, work_mean);
        ref_mean[r.slot] = tmp;
        ref_cnt[r.slot] = c;
        for (int i = 0; i < CHANNELS; i++) work_mean[i] = '0;
        work_cnt = '0;
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < CHANNELS; i++) ref_mean[r.slot][i] = '0;
        ref_cnt[r.slot] = '0;
      end
      default: begin
        found = 0;
        multi = 0;
        first = 0;
        for (int p = 0; p < SLOTS; p++) begin
          ok = 1;
          for (int i = 0; i < CHANNELS; i++) begin
            d = (ref_mean[p][i] > work_mean[i]) ? 32'(ref_mean[p][i] - work_mean[i])
                                                : 32'(work_mean[i] - ref_mean[p][i]);
            if (d > 32'(tol_model)) ok = 0;
          end
          if (ok) begin
            if (!found) begin
              found = 1;
              first = 32'(p);
            end else begin
              multi = 1;
            end
          end
        end
        res.matched = found && !multi;
        res.matched_slot = (found && !multi) ? SLOT_W'(first) : '0;
        res.ambiguous = multi;
        expected_results.push_back(res);
        classified++;
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      predict_request(in_req);
      accepted++;
    end
    if (rst_n && !(start && !busy && pending_reqs.size() > 0) && start && !busy) begin
      start <= 1'b0;
    end else if (rst_n && (!start || !busy) && pending_reqs.size() > 0 &&
                 $urandom_range(99) >= idle_pct) begin
      in_req <= pending_reqs.pop_front();
      start <= 1'b1;
    end else if (rst_n && start && !busy) begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_res);
        errors++;
      end else begin
        out_res_t e;
        e = expected_results.pop_front();
        if (e.matched !== out_res.matched || e.matched_slot !== out_res.matched_slot ||
            e.ambiguous !== out_res.ambiguous) begin
          $display("%0t mismatch expected %p actual %p", $time, e, out_res);
          errors++;
        end
      end
    end
  end

  function automatic in_req_t make_req(func_t f, logic [7:0] a, logic [7:0] b,
                                       logic [7:0] c, logic [2:0] s);
    in_req_t r;
    r.func = f;
    r.filter_a = a;
    r.filter_b = b;
    r.filter_c = c;
    r.slot = s;
    return r;
  endfunction

  function automatic in_req_t rand_sample();
    logic [7:0] v [3];
    for (int i = 0; i < 3; i++) v[i] = 8'($urandom_range(255));
    if ($urandom_range(3) == 0) v[$urandom_range(2)] = '0;
    return make_req(FUNC_SAMPLE, v[0], v[1], v[2], 3'($urandom_range(7)));
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || start || busy || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tol_model = v;
  endtask

  task automatic random_phase(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 55) begin
        pending_reqs.push_back(rand_sample());
      end else if (k < 70) begin
        pending_reqs.push_back(make_req(FUNC_COMMIT, 8'($urandom), 8'($urandom),
                                        8'($urandom), 3'($urandom_range(7))));
      end else if (k < 93) begin
        pending_reqs.push_back(make_req(FUNC_CLASSIFY, 8'($urandom), 8'($urandom),
                                        8'($urandom), 3'($urandom_range(7))));
      end else begin
        pending_reqs.push_back(make_req(FUNC_CLEAR, 8'($urandom), 8'($urandom),
                                        8'($urandom), 3'($urandom_range(7))));
      end
    end
  endtask

  initial begin
    tol_model = TOL_RESET;
    for (int i = 0; i < CHANNELS; i++) work_mean[i] = '0;
    work_cnt = '0;
    for (int p = 0; p < SLOTS; p++) begin
      for (int i = 0; i < CHANNELS; i++) ref_mean[p][i] = '0;
      ref_cnt[p] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pending_reqs.push_back(make_req(FUNC_CLASSIFY, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(FUNC_COMMIT, 0, 0, 0, 7));
    pending_reqs.push_back(make_req(FUNC_SAMPLE, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(FUNC_SAMPLE, 255, 255, 255, 0));
    pending_reqs.push_back(make_req(FUNC_SAMPLE, 255, 1, 0, 0));
    pending_reqs.push_back(make_req(FUNC_SAMPLE, 1, 2, 255, 0));
    pending_reqs.push_back(make_req(FUNC_CLASSIFY, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(FUNC_COMMIT, 0, 0, 0, 2));
    pending_reqs.push_back(make_req(FUNC_SAMPLE, 0, 255, 128, 5));
    pending_reqs.push_back(make_req(FUNC_COMMIT, 0, 0, 0, 5));
    pending_reqs.push_back(make_req(FUNC_SAMPLE, 0, 255, 128, 0));
    pending_reqs.push_back(make_req(FUNC_CLASSIFY, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(FUNC_CLEAR, 255, 255, 255, 2));
    pending_reqs.push_back(make_req(FUNC_CLASSIFY, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(FUNC_CLEAR, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(FUNC_CLASSIFY, 0, 0, 0, 7));
    drain();

    write_tolerance('0);
    for (int i = 0; i < 70; i++) pending_reqs.push_back(rand_sample());
    pending_reqs.push_back(make_req(FUNC_COMMIT, 0, 0, 0, 3));
    pending_reqs.push_back(make_req(FUNC_COMMIT, 0, 0, 0, 3));
    pending_reqs.push_back(make_req(FUNC_CLASSIFY, 0, 0, 0, 3));
    random_phase(40);

    write_tolerance(13'd4096);
    idle_pct = 77;
    random_phase(70);

    write_tolerance(13'h1FFF);
    idle_pct = 37;
    random_phase(50);

    write_tolerance(13'd410);
    idle_pct = 0;
    random_phase(70);
    drain();
    idle_pct = 37;
    write_tolerance(13'd120);
    random_phase(90);
    drain();

    $display("Ran %0d requests, %0d classify results checked, tolerances from 0 to 8191.",
             accepted, classified);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
sv/fbtc_pkg.sv
sv/fbtc_div.sv
sv/filter_bank_template_classifier_unit.sv
verif/tb_top.sv
